### hw/rtl/mssm_pkg.sv
`default_nettype none

package mssm_pkg;

    localparam int unsigned SLOT_BITS = 3;
    localparam int unsigned PTR_BITS  = 4;
    localparam int unsigned OCC_BITS  = 8;
    localparam int unsigned GEN_BITS  = 32;

    localparam logic [PTR_BITS-1:0] SLOT_NONE = 4'd8;
    localparam logic [PTR_BITS-1:0] MIN_SLOTS = 4'd2;

    typedef enum logic [2:0] {
        REQ_CHOOSE   = 3'd0,
        REQ_EVICT    = 3'd1,
        REQ_STAGE    = 3'd2,
        REQ_ACTIVATE = 3'd3,
        REQ_ROLLBACK = 3'd4,
        REQ_CLEAR    = 3'd5,
        REQ_INSTALL  = 3'd6
    } t_req;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_INVALID     = 3'd1,
        ST_BUSY        = 3'd2,
        ST_NOT_FOUND   = 3'd3,
        ST_ALREADY     = 3'd4,
        ST_COMMIT_FAIL = 3'd5
    } t_status;

    typedef struct packed {
        logic [OCC_BITS-1:0] occ;
        logic [PTR_BITS-1:0] act;
        logic [PTR_BITS-1:0] piv;
        logic [PTR_BITS-1:0] stg;
    } t_slot_state;

    typedef struct packed {
        t_slot_state         state;
        t_status             status;
        logic [PTR_BITS-1:0] result;
        logic                commit_tried;
        logic                commit_done;
        logic                target;
    } t_step_out;

endpackage

`default_nettype wire

### hw/rtl/model_slot_state_manager.sv
// Slot bookkeeping for a store of model image slots.
//
// Requests enter on a command channel: a transaction is taken at a rising
// edge where start is high and busy is low. busy stays low, so a request
// may be issued in every cycle. The request is registered, worked out
// against the slot state in the following cycle, and its result appears
// on the o_ result ports with o_done high for exactly one cycle. One
// request per cycle is sustained; the slot state and registry generation
// written by one request are seen by the request immediately behind it.
//
// The slot count register is written on its own valid/ready channel
// (ready is always high); the user must do so only while no request is
// in flight, which the block itself does not enforce.
// Synchronous reset clears the occupancy mask, sets the active, pivot and
// staged slots to none, zeroes the generation, marks both registry copies
// bad and sets the slot count to two. Results cannot be held off by the
// receiver; each one is valid only in its strobe cycle.

`default_nettype none

module model_slot_state_manager #(
    parameter int unsigned MAX_SLOTS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [2:0]  i_slot,
    input  wire logic        i_evict_ok,
    input  wire logic        i_commit_ok,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [3:0]  i_cfg_data,
    output logic             o_done,
    output logic [2:0]       o_status,
    output logic [3:0]       o_result_slot,
    output logic [3:0]       o_active_now,
    output logic [3:0]       o_pivot_now,
    output logic [3:0]       o_staged_now,
    output logic [7:0]       o_occupied_now,
    output logic [31:0]      o_generation_now,
    output logic             o_commit_tried,
    output logic             o_copy_target
);
    import mssm_pkg::*;

    localparam logic [PTR_BITS-1:0] MAX_CNT = PTR_BITS'(MAX_SLOTS);

    logic                r_in_vld;
    logic [2:0]          r_req;
    logic [2:0]          r_slot;
    logic                r_evict_ok;
    logic                r_commit_ok;
    logic [3:0]          r_cfg_slots;
    t_slot_state         r_state;
    logic [GEN_BITS-1:0] r_gen;
    logic [1:0]          r_copy_good;
    logic                r_newest;
    logic                r_done;
    t_step_out           r_out;
    logic [GEN_BITS-1:0] r_gen_out;

    logic [3:0]          count;
    t_step_out           step;
    logic [GEN_BITS-1:0] n_gen;
    logic [1:0]          n_copy_good;
    logic                n_newest;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    assign count = (r_cfg_slots < MIN_SLOTS) ? MIN_SLOTS :
                   (r_cfg_slots > MAX_CNT)   ? MAX_CNT   : r_cfg_slots;

    mssm_step u_step (
        .i_req       (r_req),
        .i_slot      (r_slot),
        .i_evict_ok  (r_evict_ok),
        .i_commit_ok (r_commit_ok),
        .i_count     (count),
        .i_state     (r_state),
        .i_copy_good (r_copy_good),
        .i_newest    (r_newest),
        .o_step      (step)
    );

    always_comb begin
        n_gen       = r_gen;
        n_copy_good = r_copy_good;
        n_newest    = r_newest;
        if (step.commit_tried) begin
            n_copy_good[step.target] = step.commit_done;
            if (step.commit_done) begin
                n_newest = step.target;
                n_gen    = r_gen + GEN_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld    <= 1'b0;
            r_done      <= 1'b0;
            r_cfg_slots <= MIN_SLOTS;
            r_state     <= '{occ: '0, act: SLOT_NONE, piv: SLOT_NONE, stg: SLOT_NONE};
            r_gen       <= '0;
            r_copy_good <= '0;
            r_newest    <= 1'b0;
        end else begin
            r_in_vld <= start && !busy;
            r_done   <= r_in_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg_slots <= i_cfg_data;
            end
            if (r_in_vld) begin
                r_state     <= step.state;
                r_gen       <= n_gen;
                r_copy_good <= n_copy_good;
                r_newest    <= n_newest;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req       <= i_req_type;
            r_slot      <= i_slot;
            r_evict_ok  <= i_evict_ok;
            r_commit_ok <= i_commit_ok;
        end
        if (r_in_vld) begin
            r_out     <= step;
            r_gen_out <= n_gen;
        end
    end

    assign o_done           = r_done;
    assign o_status         = r_out.status;
    assign o_result_slot    = r_out.result;
    assign o_active_now     = r_out.state.act;
    assign o_pivot_now      = r_out.state.piv;
    assign o_staged_now     = r_out.state.stg;
    assign o_occupied_now   = r_out.state.occ;
    assign o_generation_now = r_gen_out;
    assign o_commit_tried   = r_out.commit_tried;
    assign o_copy_target    = r_out.target;

endmodule

`default_nettype wire

### hw/rtl/mssm_step.sv
`default_nettype none

module mssm_step (
    input  wire logic [2:0]                  i_req,
    input  wire logic [2:0]                  i_slot,
    input  wire logic                        i_evict_ok,
    input  wire logic                        i_commit_ok,
    input  wire logic [3:0]                  i_count,
    input  wire mssm_pkg::t_slot_state       i_state,
    input  wire logic [1:0]                  i_copy_good,
    input  wire logic                        i_newest,
    output mssm_pkg::t_step_out              o_step
);
    import mssm_pkg::*;

    t_slot_state         nxt;
    t_status             status;
    logic [PTR_BITS-1:0] result;
    logic                want;
    logic                target;
    logic [PTR_BITS-1:0] slot4;
    logic                in_range;
    logic                slot_occ;
    logic                is_act;
    logic                act_none;
    logic [PTR_BITS-1:0] c_free;
    logic [PTR_BITS-1:0] c_spare;
    logic [PTR_BITS-1:0] c_other;
    logic [PTR_BITS-1:0] choose;
    logic [PTR_BITS-1:0] rb_scan;
    logic [PTR_BITS-1:0] rb;
    logic                piv_ok;

    // Priority scans over the slots; each slot is examined independently.
    always_comb begin
        c_free  = SLOT_NONE;
        c_spare = SLOT_NONE;
        c_other = SLOT_NONE;
        rb_scan = SLOT_NONE;
        for (int i = OCC_BITS - 1; i >= 0; i--) begin
            if (PTR_BITS'(i) < i_count) begin
                if (!i_state.occ[i]) begin
                    c_free = PTR_BITS'(i);
                end
                if (PTR_BITS'(i) != i_state.act && PTR_BITS'(i) != i_state.piv) begin
                    c_spare = PTR_BITS'(i);
                end
                if (PTR_BITS'(i) != i_state.act) begin
                    c_other = PTR_BITS'(i);
                end
            end
        end
        for (int i = 0; i < OCC_BITS; i++) begin
            if (PTR_BITS'(i) < i_count && i_state.occ[i] &&
                PTR_BITS'(i) != i_state.act && PTR_BITS'(i) != i_state.stg) begin
                rb_scan = PTR_BITS'(i);
            end
        end
    end

    assign choose = (c_free != SLOT_NONE) ? c_free :
                    (c_spare != SLOT_NONE) ? c_spare : c_other;
    assign piv_ok = (i_state.piv != SLOT_NONE) && (i_state.piv != i_state.act) &&
                    !i_state.piv[3] && i_state.occ[i_state.piv[2:0]];
    assign rb     = piv_ok ? i_state.piv : rb_scan;

    assign slot4    = {1'b0, i_slot};
    assign in_range = slot4 < i_count;
    assign slot_occ = i_state.occ[i_slot];
    assign is_act   = slot4 == i_state.act;
    assign act_none = i_state.act == SLOT_NONE;
    assign target   = i_copy_good[i_newest] ? ~i_newest : 1'b0;

    always_comb begin
        nxt    = i_state;
        status = ST_OK;
        result = SLOT_NONE;
        want   = 1'b0;
        case (i_req)
            REQ_CHOOSE: begin
                result = choose;
                if (choose == SLOT_NONE) begin
                    status = ST_NOT_FOUND;
                end
            end
            REQ_EVICT: begin
                if (!in_range) begin
                    status = ST_INVALID;
                end else if (is_act) begin
                    status = ST_BUSY;
                end else if (!slot_occ) begin
                    status = ST_OK;
                end else if (!i_evict_ok) begin
                    status = ST_BUSY;
                end else begin
                    nxt.occ[i_slot] = 1'b0;
                    if (i_state.stg == slot4) begin
                        nxt.stg = SLOT_NONE;
                    end
                    if (i_state.piv == slot4) begin
                        nxt.piv = SLOT_NONE;
                    end
                    want = 1'b1;
                end
            end
            REQ_STAGE: begin
                if (!in_range) begin
                    status = ST_INVALID;
                end else if (is_act) begin
                    status = ST_BUSY;
                end else begin
                    nxt.occ[i_slot] = 1'b1;
                    nxt.stg         = slot4;
                    want            = 1'b1;
                end
            end
            REQ_ACTIVATE: begin
                if (!in_range) begin
                    status = ST_INVALID;
                end else if (!slot_occ) begin
                    status = ST_NOT_FOUND;
                end else if (is_act) begin
                    status = ST_ALREADY;
                end else if (!act_none && !i_evict_ok) begin
                    status = ST_BUSY;
                end else begin
                    nxt.piv = i_state.act;
                    nxt.act = slot4;
                    if (i_state.stg == slot4) begin
                        nxt.stg = SLOT_NONE;
                    end
                    want = 1'b1;
                end
            end
            REQ_ROLLBACK: begin
                result = rb;
                if (rb == SLOT_NONE) begin
                    status = ST_NOT_FOUND;
                end else if (!act_none && !i_evict_ok) begin
                    status = ST_BUSY;
                end else begin
                    nxt.piv = i_state.act;
                    nxt.act = rb;
                    want    = 1'b1;
                end
            end
            REQ_CLEAR: begin
                if (i_state.stg != SLOT_NONE) begin
                    if (!i_state.stg[3]) begin
                        nxt.occ[i_state.stg[2:0]] = 1'b0;
                    end
                    nxt.stg = SLOT_NONE;
                    want    = 1'b1;
                end
            end
            REQ_INSTALL: begin
                if (!in_range) begin
                    status = ST_INVALID;
                end else begin
                    nxt.occ[i_slot] = 1'b1;
                    if (i_state.stg == slot4) begin
                        nxt.stg = SLOT_NONE;
                    end
                    if (!is_act) begin
                        nxt.piv = i_state.act;
                    end
                    nxt.act = slot4;
                    want    = 1'b1;
                end
            end
            default: begin
                status = ST_INVALID;
            end
        endcase

        // A failed registry commit puts every pointer and the mask back.
        if (want && !i_commit_ok) begin
            nxt    = i_state;
            status = ST_COMMIT_FAIL;
        end
    end

    assign o_step.state        = nxt;
    assign o_step.status       = status;
    assign o_step.result       = result;
    assign o_step.commit_tried = want;
    assign o_step.commit_done  = want && i_commit_ok;
    assign o_step.target       = want ? target : 1'b0;

endmodule

`default_nettype wire

### hw/rtl/mssm_checker.sv
`default_nettype none

module mssm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_done,
    input wire logic [2:0]  o_status,
    input wire logic        o_commit_tried,
    input wire logic        o_copy_target
);
    import mssm_pkg::*;

    // Every accepted transaction gives exactly one result.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("accepted request produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##2 !o_done)
        else $error("result without a request");

    a_target_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_commit_tried) |-> !o_copy_target)
        else $error("copy target set without a commit");

    a_fail_needs_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_COMMIT_FAIL) |-> o_commit_tried)
        else $error("commit failure reported without a commit");

endmodule

bind model_slot_state_manager mssm_checker u_mssm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_done         (o_done),
    .o_status       (o_status),
    .o_commit_tried (o_commit_tried),
    .o_copy_target  (o_copy_target)
);

`default_nettype wire

### tb/model_slot_state_manager_test.sv
`timescale 1ns / 1ps

module model_slot_state_manager_test;
    import mssm_pkg::*;

    localparam logic [2:0]  REQ_UNDEFINED = 3'd7;
    localparam int unsigned SLOT_LIMIT    = 8;
    localparam int          CYCLE_LIMIT   = 200000;

    typedef struct packed {
        t_status     status;
        logic [3:0]  result_slot;
        logic [3:0]  active;
        logic [3:0]  pivot;
        logic [3:0]  staged;
        logic [7:0]  occupied;
        logic [31:0] generation;
        logic        commit_tried;
        logic        copy_target;
    } t_slot_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_req_type;
    logic [2:0]  i_slot;
    logic        i_evict_ok;
    logic        i_commit_ok;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_data;
    logic        o_done;
    logic [2:0]  o_status;
    logic [3:0]  o_result_slot;
    logic [3:0]  o_active_now;
    logic [3:0]  o_pivot_now;
    logic [3:0]  o_staged_now;
    logic [7:0]  o_occupied_now;
    logic [31:0] o_generation_now;
    logic        o_commit_tried;
    logic        o_copy_target;

    logic [3:0]  reg_slot_count = MIN_SLOTS;
    logic [7:0]  occ_mask       = '0;
    logic [3:0]  cur_active     = SLOT_NONE;
    logic [3:0]  pivot_slot     = SLOT_NONE;
    logic [3:0]  cur_staged     = SLOT_NONE;
    logic [31:0] registry_gen   = '0;
    logic [1:0]  copy_good      = '0;
    logic        latest_copy    = 1'b0;

    t_slot_outcome expected_outcomes[$];

    int sender_idle_pct = 0;
    int mismatches      = 0;
    int cycles          = 0;
    int requests_sent   = 0;
    int commits_tried   = 0;
    int commits_failed  = 0;
    int count_writes    = 0;

    model_slot_state_manager #(
        .MAX_SLOTS(SLOT_LIMIT)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_slot          (i_slot),
        .i_evict_ok      (i_evict_ok),
        .i_commit_ok     (i_commit_ok),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_result_slot   (o_result_slot),
        .o_active_now    (o_active_now),
        .o_pivot_now     (o_pivot_now),
        .o_staged_now    (o_staged_now),
        .o_occupied_now  (o_occupied_now),
        .o_generation_now(o_generation_now),
        .o_commit_tried  (o_commit_tried),
        .o_copy_target   (o_copy_target)
    );

    always #10 i_clk = ~i_clk;

    function automatic int unsigned usable_slots();
        if (reg_slot_count < MIN_SLOTS) return MIN_SLOTS;
        if (reg_slot_count > SLOT_LIMIT) return SLOT_LIMIT;
        return reg_slot_count;
    endfunction

    function automatic t_slot_outcome predict_request(input logic [2:0] req,
                                                      input logic [2:0] slot,
                                                      input logic evict_ok,
                                                      input logic commit_ok);
        t_slot_outcome outcome;
        int unsigned   count;
        int            s;
        logic [3:0]    slot_ptr;
        t_status       st;
        logic [3:0]    res;
        logic          want;
        logic          tgt;
        logic [7:0]    saved_occ;
        logic [3:0]    saved_act;
        logic [3:0]    saved_piv;
        logic [3:0]    saved_stg;

        count     = usable_slots();
        slot_ptr  = {1'b0, slot};
        st        = ST_OK;
        res       = SLOT_NONE;
        want      = 1'b0;
        tgt       = 1'b0;
        saved_occ = occ_mask;
        saved_act = cur_active;
        saved_piv = pivot_slot;
        saved_stg = cur_staged;

        case (req)
            REQ_CHOOSE: begin
                for (s = 0; s < count; s++) begin
                    if (res == SLOT_NONE && !occ_mask[s]) res = s[3:0];
                end
                for (s = 0; s < count; s++) begin
                    if (res == SLOT_NONE && s != cur_active && s != pivot_slot) res = s[3:0];
                end
                for (s = 0; s < count; s++) begin
                    if (res == SLOT_NONE && s != cur_active) res = s[3:0];
                end
                if (res == SLOT_NONE) st = ST_NOT_FOUND;
            end
            REQ_EVICT: begin
                if (slot_ptr >= count) st = ST_INVALID;
                else if (slot_ptr == cur_active) st = ST_BUSY;
                else if (!occ_mask[slot]) st = ST_OK;
                else if (!evict_ok) st = ST_BUSY;
                else begin
                    occ_mask[slot] = 1'b0;
                    if (cur_staged == slot_ptr) cur_staged = SLOT_NONE;
                    if (pivot_slot == slot_ptr) pivot_slot = SLOT_NONE;
                    want = 1'b1;
                end
            end
            REQ_STAGE: begin
                if (slot_ptr >= count) st = ST_INVALID;
                else if (slot_ptr == cur_active) st = ST_BUSY;
                else begin
                    occ_mask[slot] = 1'b1;
                    cur_staged = slot_ptr;
                    want = 1'b1;
                end
            end
            REQ_ACTIVATE: begin
                if (slot_ptr >= count) st = ST_INVALID;
                else if (!occ_mask[slot]) st = ST_NOT_FOUND;
                else if (slot_ptr == cur_active) st = ST_ALREADY;
                else if (cur_active != SLOT_NONE && !evict_ok) st = ST_BUSY;
                else begin
                    pivot_slot = cur_active;
                    cur_active = slot_ptr;
                    if (cur_staged == slot_ptr) cur_staged = SLOT_NONE;
                    want = 1'b1;
                end
            end
            REQ_ROLLBACK: begin
                if (pivot_slot != SLOT_NONE && pivot_slot != cur_active &&
                    occ_mask[pivot_slot[2:0]]) begin
                    res = pivot_slot;
                end else begin
                    for (s = 0; s < count; s++) begin
                        if (occ_mask[s] && s != cur_active && s != cur_staged) res = s[3:0];
                    end
                end
                if (res == SLOT_NONE) st = ST_NOT_FOUND;
                else if (cur_active != SLOT_NONE && !evict_ok) st = ST_BUSY;
                else begin
                    pivot_slot = cur_active;
                    cur_active = res;
                    want = 1'b1;
                end
            end
            REQ_CLEAR: begin
                if (cur_staged != SLOT_NONE) begin
                    occ_mask[cur_staged[2:0]] = 1'b0;
                    cur_staged = SLOT_NONE;
                    want = 1'b1;
                end
            end
            REQ_INSTALL: begin
                if (slot_ptr >= count) st = ST_INVALID;
                else begin
                    occ_mask[slot] = 1'b1;
                    if (cur_staged == slot_ptr) cur_staged = SLOT_NONE;
                    if (cur_active != slot_ptr) pivot_slot = cur_active;
                    cur_active = slot_ptr;
                    want = 1'b1;
                end
            end
            default: begin
                st = ST_INVALID;
            end
        endcase

        if (want) begin
            commits_tried++;
            tgt = copy_good[latest_copy] ? ~latest_copy : 1'b0;
            if (commit_ok) begin
                copy_good[tgt] = 1'b1;
                latest_copy = tgt;
                registry_gen = registry_gen + 32'd1;
            end else begin
                commits_failed++;
                copy_good[tgt] = 1'b0;
                occ_mask = saved_occ;
                cur_active = saved_act;
                pivot_slot = saved_piv;
                cur_staged = saved_stg;
                st = ST_COMMIT_FAIL;
            end
        end

        outcome.status       = st;
        outcome.result_slot  = res;
        outcome.active       = cur_active;
        outcome.pivot        = pivot_slot;
        outcome.staged       = cur_staged;
        outcome.occupied     = occ_mask;
        outcome.generation   = registry_gen;
        outcome.commit_tried = want;
        outcome.copy_target  = want ? tgt : 1'b0;
        return outcome;
    endfunction

    task automatic issue_request(input logic [2:0] req, input logic [2:0] slot,
                                 input logic evict_ok, input logic commit_ok);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < sender_idle_pct) gap++;
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start       <= 1'b1;
        i_req_type  <= req;
        i_slot      <= slot;
        i_evict_ok  <= evict_ok;
        i_commit_ok <= commit_ok;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        expected_outcomes.push_back(predict_request(req, slot, evict_ok, commit_ok));
        requests_sent++;
    endtask

    task automatic drain_requests();
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_outcomes.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_slot_count(input logic [3:0] value);
        drain_requests();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        reg_slot_count = value;
        count_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_checker
        t_slot_outcome exp_out;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (expected_outcomes.size() == 0) begin
                mismatches++;
                $display("%0t: result with none expected, expected nothing, actual status %0d",
                         $time, o_status);
            end else begin
                exp_out = expected_outcomes.pop_front();
                check_field("status", exp_out.status, o_status);
                check_field("result_slot", exp_out.result_slot, o_result_slot);
                check_field("active_now", exp_out.active, o_active_now);
                check_field("pivot_now", exp_out.pivot, o_pivot_now);
                check_field("staged_now", exp_out.staged, o_staged_now);
                check_field("occupied_now", exp_out.occupied, o_occupied_now);
                check_field("generation_now", exp_out.generation, o_generation_now);
                check_field("commit_tried", exp_out.commit_tried, o_commit_tried);
                check_field("copy_target", exp_out.copy_target, o_copy_target);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: run stopped after %0d cycles", $time, cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic test_reset_state();
        issue_request(REQ_CHOOSE, 3'd5, 1'b1, 1'b1);
        issue_request(REQ_ROLLBACK, 3'd0, 1'b1, 1'b1);
        issue_request(REQ_CLEAR, 3'd0, 1'b1, 1'b1);
        issue_request(REQ_EVICT, 3'd0, 1'b0, 1'b1);
    endtask

    task automatic test_slot_lifecycle();
        issue_request(REQ_STAGE, 3'd0, 1'b1, 1'b1);
        issue_request(REQ_ACTIVATE, 3'd0, 1'b0, 1'b1);
        issue_request(REQ_INSTALL, 3'd1, 1'b1, 1'b1);
        issue_request(REQ_CHOOSE, 3'd0, 1'b1, 1'b1);
        issue_request(REQ_ACTIVATE, 3'd0, 1'b0, 1'b1);
        issue_request(REQ_ROLLBACK, 3'd0, 1'b1, 1'b1);
        issue_request(REQ_ACTIVATE, 3'd0, 1'b1, 1'b1);
        issue_request(REQ_EVICT, 3'd0, 1'b1, 1'b1);
        issue_request(REQ_EVICT, 3'd1, 1'b0, 1'b1);
        issue_request(REQ_EVICT, 3'd1, 1'b1, 1'b1);
        issue_request(REQ_ROLLBACK, 3'd0, 1'b1, 1'b1);
        issue_request(REQ_STAGE, 3'd1, 1'b1, 1'b1);
        issue_request(REQ_CLEAR, 3'd0, 1'b1, 1'b1);
    endtask

    task automatic test_commit_failure();
        issue_request(REQ_INSTALL, 3'd1, 1'b1, 1'b0);
        issue_request(REQ_STAGE, 3'd1, 1'b1, 1'b0);
        issue_request(REQ_INSTALL, 3'd1, 1'b1, 1'b1);
    endtask

    task automatic test_invalid_requests();
        issue_request(REQ_EVICT, 3'd7, 1'b1, 1'b1);
        issue_request(REQ_ACTIVATE, 3'd3, 1'b1, 1'b1);
        issue_request(REQ_INSTALL, 3'd7, 1'b1, 1'b1);
        issue_request(REQ_UNDEFINED, 3'd2, 1'b1, 1'b1);
    endtask

    task automatic test_slot_count_extremes();
        write_slot_count(4'd0);
        issue_request(REQ_INSTALL, 3'd2, 1'b1, 1'b1);
        write_slot_count(4'd15);
        issue_request(REQ_INSTALL, 3'd7, 1'b1, 1'b1);
        write_slot_count(4'd9);
        issue_request(REQ_CHOOSE, 3'd0, 1'b1, 1'b1);
        write_slot_count(4'd1);
        issue_request(REQ_STAGE, 3'd1, 1'b1, 1'b1);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int n_items);
        int unsigned count;
        int          i;
        int          pick;
        logic [2:0]  req;
        logic [2:0]  slot;
        sender_idle_pct = idle_pct;
        for (i = 0; i < n_items; i++) begin
            if (i % 125 == 0) begin
                case ((i / 125) % 4)
                    0:       write_slot_count(4'(SLOT_LIMIT));
                    1:       write_slot_count(MIN_SLOTS);
                    default: write_slot_count(4'($urandom_range(0, 15)));
                endcase
            end
            count = usable_slots();
            pick  = $urandom_range(0, 99);
            if (pick < 8) req = REQ_CHOOSE;
            else if (pick < 20) req = REQ_EVICT;
            else if (pick < 35) req = REQ_STAGE;
            else if (pick < 55) req = REQ_ACTIVATE;
            else if (pick < 70) req = REQ_ROLLBACK;
            else if (pick < 78) req = REQ_CLEAR;
            else if (pick < 98) req = REQ_INSTALL;
            else req = REQ_UNDEFINED;
            if ($urandom_range(0, 9) < 9) slot = 3'($urandom_range(0, count - 1));
            else slot = 3'($urandom_range(0, 7));
            issue_request(req, slot, $urandom_range(0, 9) != 0, $urandom_range(0, 11) != 0);
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req_type  = REQ_CHOOSE;
        i_slot      = 3'd0;
        i_evict_ok  = 1'b0;
        i_commit_ok = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = 4'd0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_slot_lifecycle();
        test_commit_failure();
        test_invalid_requests();
        test_slot_count_extremes();
        test_random_traffic(16, 700);
        test_random_traffic(78, 700);
        test_random_traffic(0, 600);

        drain_requests();
        repeat (4) @(posedge i_clk);
        $display("Ran %0d requests under %0d slot-count writes, including out-of-range counts.",
                 requests_sent, count_writes);
        $display("Registry commits attempted: %0d, of which %0d failed; final generation %0d.",
                 commits_tried, commits_failed, registry_gen);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### model_slot_state_manager.f
hw/rtl/mssm_pkg.sv
hw/rtl/mssm_step.sv
hw/rtl/model_slot_state_manager.sv
hw/rtl/mssm_checker.sv
tb/model_slot_state_manager_test.sv
